// ===== hdl/table_linear_interpolator_defines.svh =====
// assertion macros for the table interpolator
// expects aclk and aresetn in the scope that uses them
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// consequent checked in the same cycle
`define TLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tli_pkg.sv =====
// package for the table interpolator: sizes, register map, control word
// layout and the microcode rom; no dependencies
`timescale 1ns / 1ps

package tli_pkg;

    localparam int MAX_POINTS = 16;
    localparam int VALUE_W    = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int MIN_POINTS = 2;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int DIV_STEPS  = PROD_W / 2;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int ENTRY_W    = 2 * VALUE_W;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_POINTS_IN_USE = 1'b0;
    localparam logic [CNT_W-1:0] POINTS_RESET = CNT_W'(2);

    // program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RD0  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RDL  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_RD1  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SRCH = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RDS  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LEFT = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIFF = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MAG  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MUL  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DIV  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_SUM  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_ERR  = 4'd13;
    localparam logic [STEP_W-1:0] STEP_YL   = 4'd14;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_CLAMP_LO,
        OP_CLAMP_HI,
        OP_SEARCH,
        OP_LEFT,
        OP_DIFF,
        OP_MAG,
        OP_MUL,
        OP_DIV,
        OP_SUM,
        OP_OUT,
        OP_ERR,
        OP_YL
    } op_t;

    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_SEG,
        ADDR_SEG1,
        ADDR_SEG2
    } addr_sel_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_START,
        COND_ERR,
        COND_MORE,
        COND_WZERO,
        COND_CNT,
        COND_FREE
    } cond_t;

    // hold: when the condition is false, stay on the step instead of advancing
    typedef struct packed {
        logic              hold;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        addr_sel_t         addr;
        op_t               op;
    } uword_t;

    function automatic uword_t uw(input logic hold, input cond_t cond,
                                  input logic [STEP_W-1:0] target,
                                  input addr_sel_t addr, input op_t op);
        uword_t w;
        w.hold   = hold;
        w.cond   = cond;
        w.target = target;
        w.addr   = addr;
        w.op     = op;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            STEP_IDLE: w = uw(1'b1, COND_START,  STEP_RD0,  ADDR_ZERO, OP_START);
            STEP_RD0:  w = uw(1'b0, COND_ERR,    STEP_ERR,  ADDR_ZERO, OP_NONE);
            STEP_RDL:  w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_LAST, OP_CLAMP_LO);
            STEP_RD1:  w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_SEG1, OP_CLAMP_HI);
            STEP_SRCH: w = uw(1'b0, COND_MORE,   STEP_SRCH, ADDR_SEG2, OP_SEARCH);
            STEP_RDS:  w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_SEG,  OP_NONE);
            STEP_LEFT: w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_SEG1, OP_LEFT);
            STEP_DIFF: w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_ZERO, OP_DIFF);
            STEP_MAG:  w = uw(1'b0, COND_WZERO,  STEP_YL,   ADDR_ZERO, OP_MAG);
            STEP_MUL:  w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_ZERO, OP_MUL);
            STEP_DIV:  w = uw(1'b0, COND_CNT,    STEP_DIV,  ADDR_ZERO, OP_DIV);
            STEP_SUM:  w = uw(1'b0, COND_NEVER,  STEP_IDLE, ADDR_ZERO, OP_SUM);
            STEP_OUT:  w = uw(1'b1, COND_FREE,   STEP_IDLE, ADDR_ZERO, OP_OUT);
            STEP_ERR:  w = uw(1'b0, COND_ALWAYS, STEP_OUT,  ADDR_ZERO, OP_ERR);
            STEP_YL:   w = uw(1'b0, COND_ALWAYS, STEP_OUT,  ADDR_ZERO, OP_YL);
            default:   w = uw(1'b0, COND_ALWAYS, STEP_IDLE, ADDR_ZERO, OP_NONE);
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/table_linear_interpolator.sv =====
// Piecewise linear interpolator over a table of up to 16 (x, y) breakpoints.
// A write item (mode 0) stores one breakpoint. An evaluate item (mode 1)
// runs a short microcode program: clamp, linear search, then y_left +
// (y_right - y_left) * (x - x_left) / (x_right - x_left) with a
// 2-bit-per-cycle restoring divider, saturated to 16 bits. The search walks
// the single table read port one breakpoint per cycle; the segment found is
// 0 to 14. A zero-width segment skips the multiply and divide and gives
// y_left, and fewer than two points in use give a size error with a zero
// result. A new item is accepted only while the program is idle. The table
// holds nothing meaningful until written and needs no clearing after reset.
// A finished result waits in the output register while the next item is
// accepted. points_in_use sits at APB byte address 0.
// depends on tli_pkg, tli_ram and table_linear_interpolator_defines.svh
`timescale 1ns / 1ps
`include "table_linear_interpolator_defines.svh"

module table_linear_interpolator import tli_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [IDX_W-1:0]          s_point_index,
    input  logic signed [VALUE_W-1:0] s_point_x,
    input  logic signed [VALUE_W-1:0] s_point_y,
    input  logic signed [VALUE_W-1:0] s_query_x,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_result_y,
    output logic                      m_size_error,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready
);

    // control state
    logic [STEP_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]  piu_reg, piu_next;
    logic              m_valid_reg, m_valid_next;

    // datapath
    logic signed [VALUE_W-1:0] qx_reg, qx_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic                      err_reg, err_next;
    logic                      lo_reg, lo_next;
    logic [IDX_W-1:0]          seg_reg, seg_next;
    logic signed [VALUE_W-1:0] xr_reg, xr_next;
    logic signed [VALUE_W-1:0] xl_reg, xl_next;
    logic signed [VALUE_W-1:0] yl_reg, yl_next;
    logic signed [VALUE_W:0]   w_reg, w_next;
    logic signed [VALUE_W:0]   dx_reg, dx_next;
    logic signed [VALUE_W:0]   dy_reg, dy_next;
    logic [VALUE_W-1:0]        mw_reg, mw_next;
    logic [VALUE_W-1:0]        mdx_reg, mdx_next;
    logic [VALUE_W-1:0]        mdy_reg, mdy_next;
    logic                      neg_reg, neg_next;
    logic [PROD_W-1:0]         quo_reg, quo_next;
    logic [VALUE_W-1:0]        rem_reg, rem_next;
    logic [DCNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    logic                      flag_reg, flag_next;
    logic signed [VALUE_W-1:0] m_result_y_reg, m_result_y_next;
    logic                      m_size_error_reg, m_size_error_next;

    uword_t                    uword;
    logic                      eval_accept;
    logic                      wr_accept;
    logic                      out_free;
    logic                      out_load;
    logic                      more;
    logic                      cond_true;
    logic                      cfg_wr;
    logic [IDX_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]        rd_data;
    logic signed [VALUE_W-1:0] rdx;
    logic signed [VALUE_W-1:0] rdy;
    logic [VALUE_W:0]          div1;
    logic [VALUE_W:0]          div2;
    logic signed [PROD_W+1:0]  q_signed;
    logic signed [PROD_W+1:0]  sum_full;
    logic signed [VALUE_W-1:0] sum_sat;

    function automatic logic [VALUE_W-1:0] mag(input logic signed [VALUE_W:0] v);
        return v[VALUE_W] ? VALUE_W'(-v) : VALUE_W'(v);
    endfunction

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [VALUE_W:0] div_step(input logic [VALUE_W-1:0] rem,
                                                  input logic qbit,
                                                  input logic [VALUE_W-1:0] d);
        logic [VALUE_W:0] t;
        t = {rem, qbit};
        if (t >= {1'b0, d}) begin
            return {1'b1, VALUE_W'(t - {1'b0, d})};
        end
        return {1'b0, t[VALUE_W-1:0]};
    endfunction

    assign uword       = ucode_rom(pc_reg);
    assign s_ready     = (pc_reg == STEP_IDLE);
    assign eval_accept = s_valid & s_ready & s_mode;
    assign wr_accept   = s_valid & s_ready & ~s_mode;
    assign out_free    = ~m_valid_reg | m_ready;
    assign out_load    = (uword.op == OP_OUT) & out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_POINTS_IN_USE)
                    ? APB_DATA_W'(piu_reg) : '0;

    // breakpoint table, x in the upper half of each entry
    tli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_accept),
        .wr_addr (s_point_index),
        .wr_data ({s_point_x, s_point_y}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rdx = rd_data[ENTRY_W-1:VALUE_W];
    assign rdy = rd_data[VALUE_W-1:0];

    always_comb begin
        unique case (uword.addr)
            ADDR_ZERO: rd_addr = '0;
            ADDR_LAST: rd_addr = IDX_W'(n_reg - CNT_W'(1));
            ADDR_SEG:  rd_addr = seg_reg;
            ADDR_SEG1: rd_addr = seg_reg + IDX_W'(1);
            ADDR_SEG2: rd_addr = seg_reg + IDX_W'(2);
            default:   rd_addr = '0;
        endcase
    end

    // keep walking while the next breakpoint is still left of x and another segment is in use
    assign more = ((CNT_W'(seg_reg) + CNT_W'(2)) < n_reg) && (qx_reg > rdx);

    assign div1 = div_step(rem_reg, quo_reg[PROD_W-1], mw_reg);
    assign div2 = div_step(div1[VALUE_W-1:0], quo_reg[PROD_W-2], mw_reg);

    assign q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign sum_full = $signed({{(PROD_W + 2 - VALUE_W){yl_reg[VALUE_W-1]}}, yl_reg})
                      + q_signed;

    // saturate when the upper bits are not all copies of the sign
    always_comb begin
        if (sum_full[PROD_W+1:VALUE_W-1] == '0 || sum_full[PROD_W+1:VALUE_W-1] == '1) begin
            sum_sat = sum_full[VALUE_W-1:0];
        end else if (sum_full[PROD_W+1]) begin
            sum_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    // sequencer
    always_comb begin
        unique case (uword.cond)
            COND_NEVER:  cond_true = 1'b0;
            COND_ALWAYS: cond_true = 1'b1;
            COND_START:  cond_true = eval_accept;
            COND_ERR:    cond_true = err_reg;
            COND_MORE:   cond_true = more;
            COND_WZERO:  cond_true = (w_reg == '0);
            COND_CNT:    cond_true = (cnt_reg != '0);
            COND_FREE:   cond_true = out_free;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb begin
        priority if (cond_true) begin
            pc_next = uword.target;
        end else if (uword.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + STEP_W'(1);
        end
    end

    // datapath actions
    always_comb begin
        qx_next   = qx_reg;
        n_next    = n_reg;
        err_next  = err_reg;
        lo_next   = lo_reg;
        seg_next  = seg_reg;
        xr_next   = xr_reg;
        xl_next   = xl_reg;
        yl_next   = yl_reg;
        w_next    = w_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        mw_next   = mw_reg;
        mdx_next  = mdx_reg;
        mdy_next  = mdy_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        flag_next = flag_reg;
        unique case (uword.op)
            OP_NONE, OP_OUT: begin
            end
            OP_START: begin
                if (eval_accept) begin
                    qx_next  = s_query_x;
                    n_next   = (piu_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : piu_reg;
                    err_next = (piu_reg < CNT_W'(MIN_POINTS));
                    seg_next = '0;
                end
            end
            OP_CLAMP_LO: begin
                if (qx_reg < rdx) begin
                    qx_next = rdx;
                    lo_next = 1'b1;
                end else begin
                    lo_next = 1'b0;
                end
            end
            OP_CLAMP_HI: begin
                if (!lo_reg && qx_reg > rdx) begin
                    qx_next = rdx;
                end
            end
            OP_SEARCH: begin
                xr_next = rdx;
                if (more) begin
                    seg_next = seg_reg + IDX_W'(1);
                end
            end
            OP_LEFT: begin
                xl_next = rdx;
                yl_next = rdy;
            end
            OP_DIFF: begin
                w_next  = {xr_reg[VALUE_W-1], xr_reg} - {xl_reg[VALUE_W-1], xl_reg};
                dx_next = {qx_reg[VALUE_W-1], qx_reg} - {xl_reg[VALUE_W-1], xl_reg};
                dy_next = {rdy[VALUE_W-1], rdy} - {yl_reg[VALUE_W-1], yl_reg};
            end
            OP_MAG: begin
                mw_next  = mag(w_reg);
                mdx_next = mag(dx_reg);
                mdy_next = mag(dy_reg);
                neg_next = dy_reg[VALUE_W] ^ dx_reg[VALUE_W] ^ w_reg[VALUE_W];
            end
            OP_MUL: begin
                quo_next = PROD_W'(mdy_reg) * PROD_W'(mdx_reg);
                rem_next = '0;
                cnt_next = DCNT_W'(DIV_STEPS - 1);
            end
            OP_DIV: begin
                rem_next = div2[VALUE_W-1:0];
                quo_next = {quo_reg[PROD_W-3:0], div1[VALUE_W], div2[VALUE_W]};
                cnt_next = cnt_reg - DCNT_W'(1);
            end
            OP_SUM: begin
                res_next  = sum_sat;
                flag_next = 1'b0;
            end
            OP_ERR: begin
                res_next  = '0;
                flag_next = 1'b1;
            end
            OP_YL: begin
                res_next  = yl_reg;
                flag_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // output register and configuration
    always_comb begin
        m_valid_next      = out_load | (m_valid_reg & ~m_ready);
        m_result_y_next   = out_load ? res_reg : m_result_y_reg;
        m_size_error_next = out_load ? flag_reg : m_size_error_reg;
        piu_next          = piu_reg;
        if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_POINTS_IN_USE) begin
            piu_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_IDLE;
            piu_reg     <= POINTS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            piu_reg     <= piu_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        qx_reg           <= qx_next;
        n_reg            <= n_next;
        err_reg          <= err_next;
        lo_reg           <= lo_next;
        seg_reg          <= seg_next;
        xr_reg           <= xr_next;
        xl_reg           <= xl_next;
        yl_reg           <= yl_next;
        w_reg            <= w_next;
        dx_reg           <= dx_next;
        dy_reg           <= dy_next;
        mw_reg           <= mw_next;
        mdx_reg          <= mdx_next;
        mdy_reg          <= mdy_next;
        neg_reg          <= neg_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        cnt_reg          <= cnt_next;
        res_reg          <= res_next;
        flag_reg         <= flag_next;
        m_result_y_reg   <= m_result_y_next;
        m_size_error_reg <= m_size_error_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_result_y   = m_result_y_reg;
    assign m_size_error = m_size_error_reg;

    `TLI_ASSERT_NEXT(a_eval_starts, s_valid && s_ready && s_mode, pc_reg == STEP_RD0, "evaluate item did not start the program")
    `TLI_ASSERT_NOW(a_result_from_out, $rose(m_valid), $past(pc_reg) == STEP_OUT, "result appeared outside the output step")
    `TLI_ASSERT_NOW(a_error_gives_zero, m_valid && m_size_error, m_result_y == '0, "size error result is not zero")
    `TLI_ASSERT_NOW(a_search_bound, pc_reg == STEP_SRCH, (CNT_W'(seg_reg) + CNT_W'(2)) <= n_reg, "search ran past the points in use")

endmodule

// ===== hdl/tli_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== test/tb.sv =====
// self-checking testbench for table_linear_interpolator: drives write and evaluate items and
// apb register writes, and checks every result against a scoreboard that tracks the table
// depends on tli_pkg and the table_linear_interpolator rtl
`timescale 1ns / 1ps

module tb import tli_pkg::*; ();

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;
    localparam int UNUSED_REG   = 1;
    localparam int TBL_WIDE      = 0;
    localparam int TBL_NARROW    = 1;
    localparam int TBL_SCRAMBLED = 2;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 135;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct {
        logic signed [VALUE_W-1:0] result_y;
        logic                      size_error;
    } interp_result_t;

    // mirror of the breakpoint table and the points register, plus the results still owed
    class interp_tracker;
        logic [CNT_W-1:0]          points;
        logic signed [VALUE_W-1:0] xs [MAX_POINTS];
        logic signed [VALUE_W-1:0] ys [MAX_POINTS];
        interp_result_t            awaited [$];
        int                        errors;

        function new();
            points = POINTS_RESET;
            errors = 0;
        endfunction

        function void write_reg(input int reg_index, input logic [APB_DATA_W-1:0] value);
            if (reg_index == int'(REG_POINTS_IN_USE)) begin
                points = value[CNT_W-1:0];
            end
        endfunction

        function logic signed [VALUE_W-1:0] interpolated_y(input logic signed [VALUE_W-1:0] qx);
            int     n;
            int     seg;
            longint x, xl, xr, yl, yr, dx, dy, w, mag, sum;
            bit     neg;
            n = (points > MAX_POINTS) ? MAX_POINTS : int'(points);
            x = qx;
            // lower bound is tested first, which matters for a non-ascending table
            if (x < xs[0]) begin
                x = xs[0];
            end else if (x > xs[n-1]) begin
                x = xs[n-1];
            end
            seg = 0;
            while (seg + 2 < n && x > xs[seg+1]) seg++;
            xl = xs[seg];
            xr = xs[seg+1];
            yl = ys[seg];
            yr = ys[seg+1];
            w  = xr - xl;
            if (w == 0) return yl[VALUE_W-1:0];
            dx  = x - xl;
            dy  = yr - yl;
            mag = ((dy < 0) ? -dy : dy) * ((dx < 0) ? -dx : dx) / ((w < 0) ? -w : w);
            neg = ((dy < 0) != (dx < 0)) != (w < 0);
            sum = neg ? yl - mag : yl + mag;
            if (sum > VAL_MAX) sum = VAL_MAX;
            if (sum < VAL_MIN) sum = VAL_MIN;
            return sum[VALUE_W-1:0];
        endfunction

        function void note_item(input logic mode, input logic [IDX_W-1:0] idx,
                                input logic signed [VALUE_W-1:0] px,
                                input logic signed [VALUE_W-1:0] py,
                                input logic signed [VALUE_W-1:0] qx);
            interp_result_t r;
            if (mode == MODE_WRITE) begin
                xs[idx] = px;
                ys[idx] = py;
            end else begin
                if (points < MIN_POINTS) begin
                    r.result_y   = '0;
                    r.size_error = 1'b1;
                end else begin
                    r.result_y   = interpolated_y(qx);
                    r.size_error = 1'b0;
                end
                awaited.insert(awaited.size(), r);
            end
        endfunction

        function void check_result(input logic signed [VALUE_W-1:0] y, input logic err);
            interp_result_t r;
            if (awaited.size() == 0) begin
                $error("result with no evaluate item pending: result_y %0d size_error %0b",
                       y, err);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (y !== r.result_y) begin
                $error("result_y: expected %0d, got %0d", r.result_y, y);
                errors++;
            end
            if (err !== r.size_error) begin
                $error("size_error: expected %0b, got %0b", r.size_error, err);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_mode = MODE_WRITE;
    logic [IDX_W-1:0]          s_point_index = '0;
    logic signed [VALUE_W-1:0] s_point_x = '0;
    logic signed [VALUE_W-1:0] s_point_y = '0;
    logic signed [VALUE_W-1:0] s_query_x = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_result_y;
    logic                      m_size_error;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    interp_tracker tracker = new();
    int            gap_pct = 0;
    int            stall_pct = 0;
    int            hold_asks = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int unsigned   cycle_count = 0;

    table_linear_interpolator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_point_index (s_point_index),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_query_x     (s_query_x),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_y    (m_result_y),
        .m_size_error  (m_size_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when the main flow asks for one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_result_y, m_size_error);
        end
    end

    task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] px,
                             input logic signed [VALUE_W-1:0] py,
                             input logic signed [VALUE_W-1:0] qx);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_point_index <= idx;
        s_point_x     <= px;
        s_point_y     <= py;
        s_query_x     <= qx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_item(mode, idx, px, py, qx);
    endtask

    task automatic write_point(input logic [IDX_W-1:0] idx,
                               input logic signed [VALUE_W-1:0] px,
                               input logic signed [VALUE_W-1:0] py);
        send_item(MODE_WRITE, idx, px, py, VALUE_W'($urandom));
    endtask

    // the unused fields of an evaluate item carry random bits
    task automatic evaluate(input logic signed [VALUE_W-1:0] qx);
        send_item(MODE_EVAL, IDX_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom), qx);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int reg_index, input logic [APB_DATA_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * reg_index);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(reg_index, value);
    endtask

    // rewrites every slot: non-descending with wide or narrow steps, or in random order
    task automatic load_table(input int style);
        int x;
        int i;
        x = (style == TBL_NARROW) ? int'($urandom_range(65000)) - 32768
                                  : int'($urandom_range(20000)) - 32768;
        for (i = 0; i < MAX_POINTS; i++) begin
            if (style == TBL_SCRAMBLED) begin
                x = int'($urandom_range(65535)) - 32768;
            end else if (i != 0 && $urandom_range(7) != 0) begin
                x += (style == TBL_NARROW) ? int'($urandom_range(8)) : int'($urandom_range(5000));
            end
            if (x > int'(VAL_MAX)) x = int'(VAL_MAX);
            write_point(i[IDX_W-1:0], x[VALUE_W-1:0], VALUE_W'($urandom));
        end
    endtask

    // mostly close to a breakpoint, sometimes anywhere or at the ends of the range
    function automatic logic signed [VALUE_W-1:0] random_query();
        int k;
        int v;
        case ($urandom_range(9))
            0: return VALUE_W'($urandom);
            1: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default: begin
                k = $urandom_range(MAX_POINTS - 1);
                v = int'(tracker.xs[k]) + int'($urandom_range(64)) - 32;
                if (v > int'(VAL_MAX)) v = int'(VAL_MAX);
                if (v < int'(VAL_MIN)) v = int'(VAL_MIN);
                return v[VALUE_W-1:0];
            end
        endcase
    endfunction

    task automatic run_phase(input int gap, input int stall, input int pts,
                             input int style, input bit squeeze);
        configure(int'(REG_POINTS_IN_USE), pts);
        gap_pct = gap;
        stall_pct <= stall;
        if (squeeze) hold_asks <= hold_asks + 1;
        load_table(style);
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 8) begin
                write_point(IDX_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom));
            end else begin
                evaluate(random_query());
            end
        end
    endtask

    initial begin
        int i;
        int x;
        int p;
        int phase_pts [12] = '{16, 2, 31, 9, 0, 16, 17, 5, 1, 16, 12, 3};
        int phase_gap [4]  = '{0, 57, 0, 22};
        int phase_stl [4]  = '{0, 0, 57, 22};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first two slots share x, so a query at or below them lands on a zero-width segment
        for (i = 0; i < MAX_POINTS; i++) begin
            x = (i < 2) ? int'(VAL_MIN) : (i == MAX_POINTS - 1) ? int'(VAL_MAX) : -24000 + i * 3500;
            write_point(i[IDX_W-1:0], x[VALUE_W-1:0], i[0] ? VAL_MAX : VAL_MIN);
        end
        evaluate(VAL_MAX);
        configure(int'(REG_POINTS_IN_USE), MAX_POINTS);
        evaluate(VAL_MIN);
        evaluate(VAL_MAX);
        evaluate(-16'sd32000);
        evaluate(16'sd1234);
        configure(int'(REG_POINTS_IN_USE), 1);
        evaluate(16'sd0);
        configure(int'(REG_POINTS_IN_USE), 0);
        evaluate(16'sd0);
        configure(int'(REG_POINTS_IN_USE), 31);
        evaluate(16'sd20000);

        // descending start of the table: the clamp pulls x far past the last segment
        configure(int'(REG_POINTS_IN_USE), 3);
        configure(UNUSED_REG, 32'h1f);
        write_point(IDX_W'(0), 16'sd100, 16'sd0);
        write_point(IDX_W'(1), 16'sd0, VAL_MIN);
        write_point(IDX_W'(2), 16'sd1, VAL_MAX);
        evaluate(-16'sd5);
        write_point(IDX_W'(1), 16'sd0, VAL_MAX);
        write_point(IDX_W'(2), 16'sd1, VAL_MIN);
        evaluate(-16'sd5);

        for (p = 0; p < 12; p++) begin
            run_phase(phase_gap[p % 4], phase_stl[p % 4], phase_pts[p],
                      (p % 5 == 4) ? TBL_SCRAMBLED : (p % 2 == 1) ? TBL_NARROW : TBL_WIDE,
                      p == 0 || p == 8);
        end

        settle();
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
